// ===== rtl/core/column_shaded_pixel_darkener_core_assert.svh =====
// assertion macros used by the darkener core back end (csd_back)
// no dependencies; include after the timescale line
`ifndef COLUMN_SHADED_PIXEL_DARKENER_CORE_ASSERT_SVH
`define COLUMN_SHADED_PIXEL_DARKENER_CORE_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define CSD_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define CSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/csd_pkg.sv =====
// shared types, constants and helpers of the pixel darkener core
// no dependencies
`timescale 1ns / 1ps

package csd_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int CFG_W          = 12;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // q0.16 gains
    localparam logic [15:0] GAIN_095 = 16'd62259;
    localparam logic [15:0] GAIN_070 = 16'd45875;
    localparam logic [15:0] GAIN_040 = 16'd26214;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic [7:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic [7:0] alpha_out;
        logic       last_pixel;
    } t_pix_out;

    // position class of one pixel, front to back
    typedef struct packed {
        logic inner;
        logic first_row;
        logic last_row;
        logic first_col;
        logic last_col;
        logic last;
    } t_cls;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PROD,
        B_SQRT,
        B_DIV,
        B_GAIN,
        B_SCALE,
        B_DONE
    } t_bstate;

    // truncated q0.16 scaling of one byte
    function automatic logic [7:0] scale8(input logic [7:0] v, input logic [15:0] gain);
        logic [23:0] prod;
        prod = {16'b0, v} * {8'b0, gain};
        return prod[23:16];
    endfunction

endpackage

// ===== rtl/core/column_shaded_pixel_darkener_core.sv =====
// top level of the column-shaded pixel darkener core
// depends on csd_pkg, csd_front, csd_queue and csd_back
`timescale 1ns / 1ps

// Darkens a stream of BGRA pixels given in buffer order, row by row. The
// front end counts column and row, classifies each pixel (inner row, first
// or last row, first or last column) and accepts one transfer per cycle
// while the two-entry queue has room. The back end takes one pixel at a
// time: a pixel on an inner row needs the column gain, worked out by a
// bit-serial square root and a bit-serial divide, one bit per cycle each;
// a pixel on the first or last row goes straight to the scaling passes.
// The back end sets the sustained rate; the output register lets it start
// the next pixel while a result waits to be taken. image_width (offset 0)
// and image_height (offset 4) are written over the APB port and reset to
// 16; the user must write them only while the block is idle, which the
// block itself does not enforce. Writes do not clear the counters, and
// last_pixel marks the final pixel of each image.

module column_shaded_pixel_darkener_core import csd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_pix_in     i_in_data,
    // pixel output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_pix_out    o_out_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = $bits(t_pix_in) + $bits(t_cls) + XW + WW;

    // configuration registers
    logic [CFG_W-1:0] r_width, r_height;
    logic             cfg_wr;

    // front to queue
    logic             f_push, q_ready;
    t_pix_in          f_pix;
    t_cls             f_cls;
    logic [XW-1:0]    f_x;
    logic [WW-1:0]    f_w;

    // queue to back
    logic [DW-1:0]    q_data;
    logic             q_valid, q_pop;
    t_pix_in          b_pix;
    t_cls             b_cls;
    logic [XW-1:0]    b_x;
    logic [WW-1:0]    b_w;

    // no wait states; the write lands on the access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_RESET;
            r_height <= CFG_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default:          r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = {{(32 - CFG_W){1'b0}}, r_width};
            REG_IMAGE_HEIGHT: prdata = {{(32 - CFG_W){1'b0}}, r_height};
            default:          prdata = '0;
        endcase
    end

    // counters and classification
    csd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_width  (r_width),
        .i_cfg_height (r_height),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_pix        (i_in_data),
        .i_q_ready    (q_ready),
        .o_push       (f_push),
        .o_pix        (f_pix),
        .o_cls        (f_cls),
        .o_x          (f_x),
        .o_w          (f_w)
    );

    // classified pixels wait here for the back end
    csd_queue #(
        .DW    (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_pix, f_cls, f_x, f_w}),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {b_pix, b_cls, b_x, b_w} = q_data;

    // gain computation, scaling passes and output register
    csd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_pix       (b_pix),
        .i_cls       (b_cls),
        .i_x         (b_x),
        .i_w         (b_w),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

// ===== rtl/core/csd_front.sv =====
// front end: column/row counters and pixel classification
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_front import csd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_cfg_width,
    input  logic [CFG_W-1:0] i_cfg_height,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_pix_in          i_pix,
    input  logic             i_q_ready,
    output logic             o_push,
    output t_pix_in          o_pix,
    output t_cls             o_cls,
    output logic [XW-1:0]    o_x,
    output logic [WW-1:0]    o_w
);

    localparam int CWW = (WW > CFG_W) ? WW : CFG_W;
    localparam int CHW = (HW > CFG_W) ? HW : CFG_W;

    logic [XW-1:0]  r_col, n_col;
    logic [YW-1:0]  r_row, n_row;
    logic [CWW-1:0] wide_w;
    logic [CHW-1:0] wide_h;
    logic [WW-1:0]  w, col_ext, x_ext;
    logic [HW-1:0]  h, row_ext, y_ext;
    t_cls           cls;

    always_comb begin
        wide_w = CWW'(i_cfg_width);
        wide_h = CHW'(i_cfg_height);
        // zero acts as one, oversize as the maximum
        if (i_cfg_width == '0) begin
            w = WW'(1);
        end else if (wide_w > CWW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(wide_w);
        end
        if (i_cfg_height == '0) begin
            h = HW'(1);
        end else if (wide_h > CHW'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(wide_h);
        end
        // stale counters land on the last column or row
        col_ext = WW'(r_col);
        row_ext = HW'(r_row);
        x_ext   = (col_ext >= w) ? w - WW'(1) : col_ext;
        y_ext   = (row_ext >= h) ? h - HW'(1) : row_ext;

        cls.first_row = (y_ext == '0);
        cls.last_row  = (y_ext == h - HW'(1));
        cls.first_col = (x_ext == '0);
        cls.last_col  = (x_ext == w - WW'(1));
        cls.inner     = !cls.first_row && !cls.last_row;
        cls.last      = cls.last_row && cls.last_col;

        if (cls.last_col) begin
            n_col = '0;
            n_row = cls.last_row ? '0 : YW'(y_ext + HW'(1));
        end else begin
            n_col = XW'(x_ext + WW'(1));
            n_row = YW'(y_ext);
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;
    assign o_pix   = i_pix;
    assign o_cls   = cls;
    assign o_x     = XW'(x_ext);
    assign o_w     = w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== rtl/core/csd_queue.sv =====
// short first-word-fall-through queue between front and back
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_queue import csd_pkg::*; #(
    parameter int DW    = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= bump(r_wp);
            end
            if (i_pop) begin
                r_rp <= bump(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/core/csd_back.sv =====
// back end: bit-serial sqrt and divide for the column gain, scaling passes,
// output register; depends on csd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "column_shaded_pixel_darkener_core_assert.svh"

module csd_back import csd_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_pop,
    input  t_pix_in       i_pix,
    input  t_cls          i_cls,
    input  logic [XW-1:0] i_x,
    input  logic [WW-1:0] i_w,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_pix_out      o_out
);

    localparam int N    = WW + 16;
    localparam int OPW  = 2 * N;
    localparam int CNTW = $clog2(N + 1);

    localparam logic [2:0] STEP_INNER     = 3'd0;
    localparam logic [2:0] STEP_FIRST_ROW = 3'd1;
    localparam logic [2:0] STEP_LAST_ROW  = 3'd2;
    localparam logic [2:0] STEP_FIRST_COL = 3'd3;
    localparam logic [2:0] STEP_LAST_COL  = 3'd4;

    t_bstate         r_state, n_state;
    logic [CNTW-1:0] r_cnt;
    logic [2:0]      r_step;
    logic            r_out_valid;
    t_pix_out        r_out;

    logic [7:0]      r_b, r_g, r_r, r_a;
    t_cls            r_cls;
    logic [XW-1:0]   r_x;
    logic [WW-1:0]   r_w;
    logic [OPW-1:0]  r_op;
    logic [N:0]      r_rem;
    logic [N-1:0]    r_root;
    logic [WW-1:0]   r_drem;
    logic [15:0]     r_cg;

    logic            q_pop, out_load;
    logic [WW-1:0]   wx;
    logic [2*WW-1:0] prod;
    logic [N+2:0]    rem_sh, trial, sq_rem;
    logic            sq_ge;
    logic [WW:0]     dv_sh, dv_rem;
    logic            dv_ge;
    logic [31:0]     gmul;
    logic [15:0]     cg_next;
    logic            hit;
    logic [15:0]     gain_b, gain_gr;

    // datapath helpers
    always_comb begin
        wx     = WW'(r_x);
        prod   = {{WW{1'b0}}, wx} * {{WW{1'b0}}, r_w - wx};
        // one root digit per cycle
        rem_sh = {r_rem, r_op[OPW-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        sq_ge  = (rem_sh >= trial);
        sq_rem = sq_ge ? rem_sh - trial : rem_sh;
        // one quotient bit per cycle
        dv_sh  = {r_drem, r_root[N-1]};
        dv_ge  = (dv_sh >= {1'b0, r_w});
        dv_rem = dv_ge ? dv_sh - {1'b0, r_w} : dv_sh;
        gmul    = {16'b0, GAIN_040} * {16'b0, r_root[15:0]};
        cg_next = GAIN_070 + gmul[31:16];
    end

    always_comb begin
        gain_b = GAIN_095;
        case (r_step)
            STEP_INNER: begin
                hit     = r_cls.inner;
                gain_gr = r_cg;
            end
            STEP_FIRST_ROW: begin
                hit     = r_cls.first_row;
                gain_gr = GAIN_070;
            end
            STEP_LAST_ROW: begin
                hit     = r_cls.last_row;
                gain_gr = GAIN_070;
            end
            STEP_FIRST_COL: begin
                hit     = r_cls.first_col;
                gain_gr = GAIN_040;
            end
            STEP_LAST_COL: begin
                hit     = r_cls.last_col;
                gain_gr = GAIN_040;
            end
            default: begin
                hit     = 1'b0;
                gain_gr = GAIN_040;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_cls.inner ? B_PROD : B_SCALE;
                end
            end
            B_PROD: n_state = B_SQRT;
            B_SQRT: begin
                if (r_cnt == CNTW'(1)) begin
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                if (r_cnt == CNTW'(1)) begin
                    n_state = B_GAIN;
                end
            end
            B_GAIN: n_state = B_SCALE;
            B_SCALE: begin
                if (r_step == STEP_LAST_COL) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        q_pop    = (r_state == B_IDLE) && i_q_valid;
        out_load = (r_state == B_DONE) && (!r_out_valid || i_out_ready);
    end

    assign o_q_pop     = q_pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cnt       <= '0;
            r_step      <= STEP_INNER;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                B_IDLE:  r_step <= STEP_INNER;
                B_PROD:  r_cnt  <= CNTW'(N);
                B_SQRT:  r_cnt  <= (r_cnt == CNTW'(1)) ? CNTW'(N) : r_cnt - CNTW'(1);
                B_DIV:   r_cnt  <= r_cnt - CNTW'(1);
                B_SCALE: r_step <= r_step + 3'd1;
                default: r_cnt  <= r_cnt;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (q_pop) begin
                    r_b   <= i_pix.blue_in;
                    r_g   <= i_pix.green_in;
                    r_r   <= i_pix.red_in;
                    r_a   <= i_pix.alpha_in;
                    r_cls <= i_cls;
                    r_x   <= i_x;
                    r_w   <= i_w;
                end
            end
            B_PROD: begin
                r_op   <= {prod, 32'b0};
                r_rem  <= '0;
                r_root <= '0;
            end
            B_SQRT: begin
                r_op   <= {r_op[OPW-3:0], 2'b00};
                r_rem  <= sq_rem[N:0];
                r_root <= {r_root[N-2:0], sq_ge};
                r_drem <= '0;
            end
            B_DIV: begin
                r_drem <= dv_rem[WW-1:0];
                r_root <= {r_root[N-2:0], dv_ge};
            end
            B_GAIN: r_cg <= cg_next;
            B_SCALE: begin
                if (hit) begin
                    r_b <= scale8(r_b, gain_b);
                    r_g <= scale8(r_g, gain_gr);
                    r_r <= scale8(r_r, gain_gr);
                end
            end
            B_DONE: begin
                if (out_load) begin
                    r_out.blue_out   <= r_b;
                    r_out.green_out  <= r_g;
                    r_out.red_out    <= r_r;
                    r_out.alpha_out  <= r_a;
                    r_out.last_pixel <= r_cls.last;
                end
            end
            default: r_cg <= r_cg;
        endcase
    end

    `CSD_ASSERT_IMM(a_pop_has_data, i_clk, i_rst_n, q_pop, i_q_valid, "pop from empty queue")
    `CSD_ASSERT_NXT(a_load_shows_result, i_clk, i_rst_n, out_load, r_out_valid, "result lost")
    `CSD_ASSERT_IMM(a_iter_count_live, i_clk, i_rst_n, (r_state == B_SQRT) || (r_state == B_DIV), r_cnt != '0, "iteration count ran out")
    `CSD_ASSERT_IMM(a_step_in_range, i_clk, i_rst_n, r_state == B_SCALE, r_step <= STEP_LAST_COL, "scale step out of range")

endmodule
